@@ sv/sabt_pkg.sv @@
// ----------------------------------------------------------------------------
// sabt_pkg: shared constants of the segment versus box slab test
// Pipeline shape constants used by the divider, the clipper and the top level.
// ----------------------------------------------------------------------------
package sabt_pkg;

    // Quotient bits resolved per divider pipeline stage.
    localparam int DIV_STEP    = 4;
    // One clipping stage per axis.
    localparam int CLIP_STAGES = 3;
    // Multiply stage and add/saturate stage of the entry point.
    localparam int LERP_STAGES = 2;

endpackage

@@ sv/sabt_if.sv @@
// ----------------------------------------------------------------------------
// sabt_in_if / sabt_out_if: valid/ready channels of the slab test
// Query channel (segment and box) and result channel (hit and entry point).
// ----------------------------------------------------------------------------
interface sabt_in_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] seg_begin_x;
    logic signed [COORD_WIDTH-1:0] seg_begin_y;
    logic signed [COORD_WIDTH-1:0] seg_begin_z;
    logic signed [COORD_WIDTH-1:0] seg_end_x;
    logic signed [COORD_WIDTH-1:0] seg_end_y;
    logic signed [COORD_WIDTH-1:0] seg_end_z;
    logic signed [COORD_WIDTH-1:0] box_center_x;
    logic signed [COORD_WIDTH-1:0] box_center_y;
    logic signed [COORD_WIDTH-1:0] box_center_z;
    logic        [COORD_WIDTH-3:0] box_half_x;
    logic        [COORD_WIDTH-3:0] box_half_y;
    logic        [COORD_WIDTH-3:0] box_half_z;

    modport source (
        output valid, seg_begin_x, seg_begin_y, seg_begin_z,
               seg_end_x, seg_end_y, seg_end_z,
               box_center_x, box_center_y, box_center_z,
               box_half_x, box_half_y, box_half_z,
        input  ready
    );
    modport sink (
        input  valid, seg_begin_x, seg_begin_y, seg_begin_z,
               seg_end_x, seg_end_y, seg_end_z,
               box_center_x, box_center_y, box_center_z,
               box_half_x, box_half_y, box_half_z,
        output ready
    );
endinterface

interface sabt_out_if #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
);
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic        [FRAC_BITS:0]     entry_fraction;
    logic signed [COORD_WIDTH-1:0] entry_point_x;
    logic signed [COORD_WIDTH-1:0] entry_point_y;
    logic signed [COORD_WIDTH-1:0] entry_point_z;

    modport source (
        output valid, hit, entry_fraction, entry_point_x, entry_point_y, entry_point_z,
        input  ready
    );
    modport sink (
        input  valid, hit, entry_fraction, entry_point_x, entry_point_y, entry_point_z,
        output ready
    );
endinterface

@@ sv/sabt_div.sv @@
// ----------------------------------------------------------------------------
// sabt_div: pipelined fixed-point slab quotient divider
// Computes (num << FRAC_BITS) / den toward zero, saturated to the coordinate
// range, resolving DIV_STEP quotient bits per stage.
// ----------------------------------------------------------------------------
module sabt_div #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH+1:0] i_num,
    input  logic signed [COORD_WIDTH:0]   i_den,
    output logic signed [COORD_WIDTH-1:0] o_quot
);
    import sabt_pkg::*;

    localparam int C  = COORD_WIDTH;
    localparam int UW = C + 2;
    localparam int DW = C + 1;
    localparam int NW = UW + FRAC_BITS;
    localparam int RW = C + 2;
    localparam int NS = (C + DIV_STEP - 1) / DIV_STEP;

    localparam logic [C-1:0] SAT_POS = {1'b0, {(C-1){1'b1}}};
    localparam logic [C-1:0] SAT_NEG = {1'b1, {(C-1){1'b0}}};

    // Magnitude stage.
    logic [UW-1:0] r_a_un;
    logic [DW-1:0] r_a_ud;
    logic          r_a_neg;

    // Iteration stages; index 0 is the set-up stage.
    logic [RW-1:0] r_rem [NS+1];
    logic [C-1:0]  r_q   [NS+1];
    logic [C-1:0]  r_nl  [NS+1];
    logic [DW-1:0] r_ud  [NS+1];
    logic          r_neg [NS+1];
    logic          r_ovf [NS+1];

    logic [C-1:0]  r_quot;

    logic [NW-1:0] n_wide;

    assign n_wide = {r_a_un, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_un  <= i_num[UW-1] ? UW'(-i_num) : UW'(i_num);
            r_a_ud  <= i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
            r_a_neg <= i_num[UW-1] ^ i_den[DW-1];
            // The upper quotient bits are only checked for being non-zero.
            r_ovf[0] <= (n_wide >> C) >= NW'(r_a_ud);
            r_rem[0] <= RW'(n_wide >> C);
            r_q[0]   <= '0;
            r_nl[0]  <= n_wide[C-1:0];
            r_ud[0]  <= r_a_ud;
            r_neg[0] <= r_a_neg;
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [RW-1:0] n_rem;
        logic [C-1:0]  n_q;
        logic [C-1:0]  n_nl;

        always_comb begin
            n_rem = r_rem[s];
            n_q   = r_q[s];
            n_nl  = r_nl[s];
            for (int k = 0; k < DIV_STEP; k++) begin
                if (s * DIV_STEP + k < C) begin
                    n_rem = {n_rem[RW-2:0], n_nl[C-1]};
                    n_nl  = {n_nl[C-2:0], 1'b0};
                    n_q   = {n_q[C-2:0], 1'b0};
                    if (n_rem >= RW'(r_ud[s])) begin
                        n_rem  = n_rem - RW'(r_ud[s]);
                        n_q[0] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_q[s+1]   <= n_q;
                r_nl[s+1]  <= n_nl;
                r_ud[s+1]  <= r_ud[s];
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[NS]) begin
                r_quot <= (r_ovf[NS] || r_q[NS][C-1]) ? SAT_NEG : C'(-r_q[NS]);
            end else begin
                r_quot <= (r_ovf[NS] || r_q[NS][C-1]) ? SAT_POS : r_q[NS];
            end
        end
    end

    assign o_quot = $signed(r_quot);

endmodule

@@ sv/sabt_clip.sv @@
// ----------------------------------------------------------------------------
// sabt_clip: three-stage slab interval clipper
// Narrows the parameter interval [0,1] against the x, y and z slabs, one
// axis per stage, and reports the hit flag and the interval's low end.
// ----------------------------------------------------------------------------
module sabt_clip #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int LW          = 32
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_t0 [3],
    input  logic signed [COORD_WIDTH-1:0] i_t1 [3],
    output logic                          o_hit,
    output logic signed [LW-1:0]          o_lo
);
    import sabt_pkg::*;

    localparam logic signed [LW-1:0] ONE = LW'(1) << FRAC_BITS;

    logic                          r_hit [CLIP_STAGES];
    logic signed [LW-1:0]          r_lo  [CLIP_STAGES];
    logic signed [LW-1:0]          r_hi  [CLIP_STAGES];
    logic signed [COORD_WIDTH-1:0] r_t0  [CLIP_STAGES][3];
    logic signed [COORD_WIDTH-1:0] r_t1  [CLIP_STAGES][3];

    for (genvar k = 0; k < CLIP_STAGES; k++) begin : g_axis
        logic                          in_hit;
        logic signed [LW-1:0]          in_lo;
        logic signed [LW-1:0]          in_hi;
        logic signed [COORD_WIDTH-1:0] src_t0 [3];
        logic signed [COORD_WIDTH-1:0] src_t1 [3];
        logic signed [LW-1:0]          a;
        logic signed [LW-1:0]          b;
        logic signed [LW-1:0]          t_near;
        logic signed [LW-1:0]          t_far;
        logic                          n_hit;
        logic signed [LW-1:0]          n_lo;
        logic signed [LW-1:0]          n_hi;

        if (k == 0) begin : g_first
            assign in_hit = 1'b1;
            assign in_lo  = '0;
            assign in_hi  = ONE;
            assign src_t0 = i_t0;
            assign src_t1 = i_t1;
        end else begin : g_next
            assign in_hit = r_hit[k-1];
            assign in_lo  = r_lo[k-1];
            assign in_hi  = r_hi[k-1];
            assign src_t0 = r_t0[k-1];
            assign src_t1 = r_t1[k-1];
        end

        assign a = LW'(src_t0[k]);
        assign b = LW'(src_t1[k]);

        always_comb begin
            t_near = (b < a) ? b : a;
            t_far  = (b < a) ? a : b;
            n_lo   = in_lo;
            n_hi   = in_hi;
            n_hit  = in_hit;
            if (in_hit) begin
                if (t_far < in_lo || t_near > in_hi) begin
                    n_hit = 1'b0;
                end else begin
                    if (t_near > in_lo) n_lo = t_near;
                    if (t_far < in_hi)  n_hi = t_far;
                    n_hit = n_lo <= n_hi;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_hit[k] <= n_hit;
                r_lo[k]  <= n_lo;
                r_hi[k]  <= n_hi;
                for (int j = 0; j < 3; j++) begin
                    r_t0[k][j] <= src_t0[j];
                    r_t1[k][j] <= src_t1[j];
                end
            end
        end
    end

    assign o_hit = r_hit[CLIP_STAGES-1];
    assign o_lo  = r_lo[CLIP_STAGES-1];

endmodule

@@ sv/sabt_lerp.sv @@
// ----------------------------------------------------------------------------
// sabt_lerp: entry point interpolation
// Forms begin + delta * fraction with the product truncated in magnitude,
// then saturates to the coordinate range. Two register stages.
// ----------------------------------------------------------------------------
module sabt_lerp #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_begin,
    input  logic signed [COORD_WIDTH:0]   i_delta,
    input  logic        [FRAC_BITS:0]     i_frac,
    output logic signed [COORD_WIDTH-1:0] o_point
);
    localparam int C  = COORD_WIDTH;
    localparam int PW = C + FRAC_BITS + 2;
    localparam int SW = C + 3;

    localparam logic signed [SW-1:0] MAXV = SW'({1'b0, {(C-1){1'b1}}});
    localparam logic signed [SW-1:0] MINV = -SW'({1'b1, {(C-1){1'b0}}});

    logic [C:0]              n_ud;
    logic [PW-1:0]           n_prod;
    logic [C+1:0]            r_off;
    logic                    r_neg;
    logic signed [C-1:0]     r_begin;
    logic signed [SW-1:0]    n_sum;
    logic signed [C-1:0]     r_point;

    assign n_ud   = i_delta[C] ? (C+1)'(-i_delta) : (C+1)'(i_delta);
    assign n_prod = PW'(n_ud) * PW'(i_frac);

    always_comb begin
        if (r_neg) begin
            n_sum = SW'(r_begin) - SW'($signed({1'b0, r_off}));
        end else begin
            n_sum = SW'(r_begin) + SW'($signed({1'b0, r_off}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_off   <= (C+2)'(n_prod >> FRAC_BITS);
            r_neg   <= i_delta[C];
            r_begin <= i_begin;
            if (n_sum > MAXV) begin
                r_point <= C'(MAXV);
            end else if (n_sum < MINV) begin
                r_point <= C'(MINV);
            end else begin
                r_point <= C'(n_sum);
            end
        end
    end

    assign o_point = r_point;

endmodule

@@ sv/segment_aabb_slab_test.sv @@
// ----------------------------------------------------------------------------
// segment_aabb_slab_test: segment versus axis-aligned box test
// Slab clipping of a segment against a box in signed fixed point.
// ----------------------------------------------------------------------------
// Usage: queries enter on i_in, one segment and one box per transaction, and
// each produces exactly one result transaction on o_out, in order.
// A query is taken in every cycle in which i_in.ready is high, so the block
// sustains one transaction per cycle. The pipeline depth from acceptance to
// o_out.valid grows with COORD_WIDTH through the six parallel slab dividers,
// which resolve four quotient bits per stage.
// The remaining stages are input preparation, three axis clipping stages and
// a multiply stage plus an add and saturate stage for the entry point.
// On a miss hit is low and the fraction and point read zero.
// The whole pipeline advances together; when the receiver holds o_out.ready
// low with a result waiting, every stage holds and i_in.ready falls, so no
// transaction is lost or repeated. Bubbles are carried as cleared valid bits.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module segment_aabb_slab_test #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sabt_in_if.sink     i_in,
    sabt_out_if.source  o_out
);
    import sabt_pkg::*;

    localparam int C       = COORD_WIDTH;
    localparam int NS      = (C + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_LAT = NS + 3;
    localparam int SD      = DIV_LAT + CLIP_STAGES;
    localparam int L       = 1 + SD + LERP_STAGES;
    localparam int LW      = (C > FRAC_BITS + 1) ? C : FRAC_BITS + 2;

    localparam logic signed [C:0] ONE_D = (C+1)'(1) << FRAC_BITS;

    logic                 r_vld [L];
    logic                 en;

    logic signed [C-1:0]  in_b [3];
    logic signed [C-1:0]  in_e [3];
    logic signed [C-1:0]  in_c [3];
    logic        [C-3:0]  in_h [3];

    logic signed [C+1:0]  r_num0 [3];
    logic signed [C+1:0]  r_num1 [3];
    logic signed [C:0]    r_den  [3];
    logic signed [C-1:0]  r_pb   [3];
    logic signed [C:0]    r_pd   [3];

    logic signed [C-1:0]  r_sb [SD][3];
    logic signed [C:0]    r_sd [SD][3];

    logic signed [C-1:0]  t0 [3];
    logic signed [C-1:0]  t1 [3];
    logic                 clip_hit;
    logic signed [LW-1:0] clip_lo;
    logic signed [C-1:0]  point [3];

    logic                 r_hit [LERP_STAGES];
    logic [FRAC_BITS:0]   r_frac [LERP_STAGES];

    assign en         = !r_vld[L-1] || o_out.ready;
    assign i_in.ready = en;

    assign in_b = '{i_in.seg_begin_x, i_in.seg_begin_y, i_in.seg_begin_z};
    assign in_e = '{i_in.seg_end_x, i_in.seg_end_y, i_in.seg_end_z};
    assign in_c = '{i_in.box_center_x, i_in.box_center_y, i_in.box_center_z};
    assign in_h = '{i_in.box_half_x, i_in.box_half_y, i_in.box_half_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k < L; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Slab numerators, divisor (one unit for a zero delta) and side data.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_num0[a] <= (C+2)'(in_c[a]) - (C+2)'($signed({2'b00, in_h[a]}))
                             - (C+2)'(in_b[a]);
                r_num1[a] <= (C+2)'(in_c[a]) + (C+2)'($signed({2'b00, in_h[a]}))
                             - (C+2)'(in_b[a]);
                r_den[a]  <= (in_e[a] == in_b[a]) ? ONE_D
                             : (C+1)'(in_e[a]) - (C+1)'(in_b[a]);
                r_pb[a]   <= in_b[a];
                r_pd[a]   <= (C+1)'(in_e[a]) - (C+1)'(in_b[a]);
            end
            for (int a = 0; a < 3; a++) begin
                r_sb[0][a] <= r_pb[a];
                r_sd[0][a] <= r_pd[a];
            end
            for (int k = 1; k < SD; k++) begin
                r_sb[k] <= r_sb[k-1];
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_div
        sabt_div #(.COORD_WIDTH(C), .FRAC_BITS(FRAC_BITS)) u_div_near (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_num0[a]),
            .i_den  (r_den[a]),
            .o_quot (t0[a])
        );
        sabt_div #(.COORD_WIDTH(C), .FRAC_BITS(FRAC_BITS)) u_div_far (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_num1[a]),
            .i_den  (r_den[a]),
            .o_quot (t1[a])
        );
    end

    sabt_clip #(.COORD_WIDTH(C), .FRAC_BITS(FRAC_BITS), .LW(LW)) u_clip (
        .i_clk (i_clk),
        .i_en  (en),
        .i_t0  (t0),
        .i_t1  (t1),
        .o_hit (clip_hit),
        .o_lo  (clip_lo)
    );

    for (genvar a = 0; a < 3; a++) begin : g_lerp
        sabt_lerp #(.COORD_WIDTH(C), .FRAC_BITS(FRAC_BITS)) u_lerp (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_begin (r_sb[SD-1][a]),
            .i_delta (r_sd[SD-1][a]),
            .i_frac  (clip_lo[FRAC_BITS:0]),
            .o_point (point[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit[0]  <= clip_hit;
            r_frac[0] <= clip_lo[FRAC_BITS:0];
            for (int k = 1; k < LERP_STAGES; k++) begin
                r_hit[k]  <= r_hit[k-1];
                r_frac[k] <= r_frac[k-1];
            end
        end
    end

    assign o_out.valid          = r_vld[L-1];
    assign o_out.hit            = r_hit[LERP_STAGES-1];
    assign o_out.entry_fraction = r_hit[LERP_STAGES-1] ? r_frac[LERP_STAGES-1] : '0;
    assign o_out.entry_point_x  = r_hit[LERP_STAGES-1] ? point[0] : '0;
    assign o_out.entry_point_y  = r_hit[LERP_STAGES-1] ? point[1] : '0;
    assign o_out.entry_point_z  = r_hit[LERP_STAGES-1] ? point[2] : '0;

endmodule
